// ===== rtl/psi_pkg.sv =====
// Package for the plane/segment intersection block.
// Field widths, payload structs and the divider cell record. No dependencies.
package psi_pkg;

  localparam int FRAC_BITS = 16;
  localparam int CW        = 32;
  localparam int DIFF_W    = CW + 1;
  localparam int PROD_W    = DIFF_W + CW;
  localparam int DOT_W     = PROD_W + 2;
  localparam int DW        = DOT_W + 2;
  localparam int SCL_W     = DIFF_W + FRAC_BITS + 1;

  typedef logic [CW-1:0] coord_t;
  typedef logic [DIFF_W-1:0] diff_t;

  typedef struct packed {
    coord_t plane_point_x;
    coord_t plane_point_y;
    coord_t plane_point_z;
    coord_t plane_normal_x;
    coord_t plane_normal_y;
    coord_t plane_normal_z;
    coord_t seg_start_x;
    coord_t seg_start_y;
    coord_t seg_start_z;
    coord_t seg_end_x;
    coord_t seg_end_y;
    coord_t seg_end_z;
  } in_t;

  typedef struct packed {
    logic   hit;
    coord_t hit_x;
    coord_t hit_y;
    coord_t hit_z;
    coord_t out_normal_x;
    coord_t out_normal_y;
    coord_t out_normal_z;
  } out_t;

  typedef struct packed {
    logic                 hit;
    logic [DW-1:0]        den;
    logic [DW-1:0]        rem;
    logic [FRAC_BITS-1:0] q;
    coord_t [2:0]         s;
    diff_t  [2:0]         d;
    coord_t [2:0]         n;
  } cell_t;

endpackage

// ===== rtl/psi_in_if.sv =====
// Input channel interface: valid/ready plus the plane and segment payload.
// Depends on psi_pkg.
interface psi_in_if import psi_pkg::*; ();
  logic valid;
  logic ready;
  in_t  data;
  modport source(output valid, output data, input ready);
  modport sink(input valid, input data, output ready);
endinterface

// ===== rtl/psi_out_if.sv =====
// Output channel interface: valid/ready plus the intersection result.
// Depends on psi_pkg.
interface psi_out_if import psi_pkg::*; ();
  logic valid;
  logic ready;
  out_t data;
  modport source(output valid, output data, input ready);
  modport sink(input valid, input data, output ready);
endinterface

// ===== rtl/plane_segment_intersection.sv =====
// Plane/segment intersection, fully pipelined: one transfer per cycle while the output is taken.
// Stages: 3 front stages, FRAC_BITS divider cells and 2 back stages.
// Each divider cell resolves one ratio bit.
// Each stage stalls only when its successor is full; output holds until taken.
// rst_ni clears the valid bits of all stages asynchronously; no other state.
module plane_segment_intersection import psi_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  psi_in_if.sink    in_i,
  psi_out_if.source out_o
);

  logic  v   [FRAC_BITS+1];
  logic  r   [FRAC_BITS+1];
  cell_t c   [FRAC_BITS+1];

  psi_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_i    (in_i),
    .valid_o (v[0]),
    .cell_o  (c[0]),
    .ready_i (r[0])
  );

  for (genvar i = 0; i < FRAC_BITS; i++) begin : g_cell
    psi_div_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (v[i]),
      .cell_i  (c[i]),
      .ready_o (r[i]),
      .valid_o (v[i+1]),
      .cell_o  (c[i+1]),
      .ready_i (r[i+1])
    );
  end

  psi_back u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (v[FRAC_BITS]),
    .cell_i  (c[FRAC_BITS]),
    .ready_o (r[FRAC_BITS]),
    .out_o   (out_o)
  );

endmodule

// ===== rtl/psi_front.sv =====
// Front end: differences, products and dot products, three register stages.
// Emits the first divider cell record. Depends on psi_pkg, psi_in_if.
module psi_front import psi_pkg::*; (
  input  logic          clk_i,
  input  logic          rst_ni,
  psi_in_if.sink        in_i,
  output logic          valid_o,
  output cell_t         cell_o,
  input  logic          ready_i
);

  logic v1_q, v2_q, v3_q;
  logic en1, en2, en3;

  coord_t [2:0] s1_q, n1_q, s2_q, n2_q;
  diff_t  [2:0] ds1_q, de1_q, d1_q, d2_q;
  logic signed [PROD_W-1:0] pds_q [3];
  logic signed [PROD_W-1:0] pde_q [3];
  cell_t c3_q, c3_d;

  coord_t [2:0] p_w, n_w, s_w, e_w;

  assign p_w = {in_i.data.plane_point_z, in_i.data.plane_point_y, in_i.data.plane_point_x};
  assign n_w = {in_i.data.plane_normal_z, in_i.data.plane_normal_y,
                in_i.data.plane_normal_x};
  assign s_w = {in_i.data.seg_start_z, in_i.data.seg_start_y, in_i.data.seg_start_x};
  assign e_w = {in_i.data.seg_end_z, in_i.data.seg_end_y, in_i.data.seg_end_x};

  assign en3 = !v3_q || ready_i;
  assign en2 = !v2_q || en3;
  assign en1 = !v1_q || en2;
  assign in_i.ready = en1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      if (en1) v1_q <= in_i.valid;
      if (en2) v2_q <= v1_q;
      if (en3) v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en1) begin
      s1_q <= s_w;
      n1_q <= n_w;
      for (int k = 0; k < 3; k++) begin
        ds1_q[k] <= $signed({s_w[k][CW-1], s_w[k]}) - $signed({p_w[k][CW-1], p_w[k]});
        de1_q[k] <= $signed({e_w[k][CW-1], e_w[k]}) - $signed({p_w[k][CW-1], p_w[k]});
        d1_q[k]  <= $signed({e_w[k][CW-1], e_w[k]}) - $signed({s_w[k][CW-1], s_w[k]});
      end
    end
    if (en2) begin
      s2_q <= s1_q;
      n2_q <= n1_q;
      d2_q <= d1_q;
      for (int k = 0; k < 3; k++) begin
        pds_q[k] <= $signed(ds1_q[k]) * $signed(n1_q[k]);
        pde_q[k] <= $signed(de1_q[k]) * $signed(n1_q[k]);
      end
    end
    if (en3) c3_q <= c3_d;
  end

  always_comb begin
    logic signed [DOT_W-1:0] ds, de;
    logic signed [DW-1:0]    den, rem;
    ds  = pds_q[0] + pds_q[1] + pds_q[2];
    de  = pde_q[0] + pde_q[1] + pde_q[2];
    den = ds - de;
    rem = ds;
    c3_d     = '0;
    c3_d.hit = (ds > 0) && (de < 0);
    c3_d.den = den;
    c3_d.rem = rem;
    c3_d.s   = s2_q;
    c3_d.d   = d2_q;
    c3_d.n   = n2_q;
  end

  assign valid_o = v3_q;
  assign cell_o  = c3_q;

endmodule

// ===== rtl/psi_div_cell.sv =====
// One restoring division cell: shifts the remainder and resolves one ratio bit.
// Depends on psi_pkg.
module psi_div_cell import psi_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  valid_i,
  input  cell_t cell_i,
  output logic  ready_o,
  output logic  valid_o,
  output cell_t cell_o,
  input  logic  ready_i
);

  logic  v_q;
  cell_t c_q, c_d;
  logic  en;

  assign en      = !v_q || ready_i;
  assign ready_o = en;

  always_comb begin
    logic [DW-1:0] rem2;
    rem2 = {cell_i.rem[DW-2:0], 1'b0};
    c_d  = cell_i;
    if (rem2 >= cell_i.den) begin
      c_d.rem = rem2 - cell_i.den;
      c_d.q   = {cell_i.q[FRAC_BITS-2:0], 1'b1};
    end else begin
      c_d.rem = rem2;
      c_d.q   = {cell_i.q[FRAC_BITS-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= 1'b0;
    end else if (en) begin
      v_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) c_q <= c_d;
  end

  assign valid_o = v_q;
  assign cell_o  = c_q;

endmodule

// ===== rtl/psi_back.sv =====
// Back end: scales the segment direction by the ratio, adds the start point,
// and holds the result (all zero on a miss) in the output register. Depends on psi_pkg, psi_out_if.
module psi_back import psi_pkg::*; (
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   valid_i,
  input  cell_t  cell_i,
  output logic   ready_o,
  psi_out_if.source out_o
);

  logic v1_q, v2_q, en1, en2;
  logic         hit1_q;
  coord_t [2:0] s1_q, n1_q;
  logic signed [SCL_W-1:0] prod_q [3];
  out_t o_q, o_d;

  assign en2     = !v2_q || out_o.ready;
  assign en1     = !v1_q || en2;
  assign ready_o = en1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else begin
      if (en1) v1_q <= valid_i;
      if (en2) v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en1) begin
      hit1_q <= cell_i.hit;
      s1_q   <= cell_i.s;
      n1_q   <= cell_i.n;
      for (int k = 0; k < 3; k++) begin
        prod_q[k] <= $signed(cell_i.d[k]) * $signed({1'b0, cell_i.q});
      end
    end
    if (en2) o_q <= o_d;
  end

  always_comb begin
    logic signed [SCL_W-1:0] st [3];
    coord_t [2:0] h;
    for (int k = 0; k < 3; k++) begin
      st[k] = prod_q[k] >>> FRAC_BITS;
      h[k]  = s1_q[k] + st[k][CW-1:0];
    end
    o_d = '0;
    if (hit1_q) begin
      o_d.hit          = 1'b1;
      o_d.hit_x        = h[0];
      o_d.hit_y        = h[1];
      o_d.hit_z        = h[2];
      o_d.out_normal_x = n1_q[0];
      o_d.out_normal_y = n1_q[1];
      o_d.out_normal_z = n1_q[2];
    end
  end

  assign out_o.valid = v2_q;
  assign out_o.data  = o_q;

endmodule
